FILE: rtl/h264au_pkg.sv
// shared types and constants for the annex-b access unit splitter
// no dependencies; imported by every rtl module of the block
package h264au_pkg;

  // lookahead window and start code bytes
  localparam int WIN_DEPTH = 5;
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // nal unit types that are passed through
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_SPS   = 5'd7;
  localparam logic [4:0] NAL_PPS   = 5'd8;
  localparam logic [4:0] NAL_AUD   = 5'd9;

  // field widths
  localparam int BYTES_W    = 24;
  localparam int INDEX_W    = 32;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 8;
  localparam int OUT_DATA_W = 104;

  // timestamp arithmetic: quotient of index * 1000 / rate fits in 42 bits
  localparam int MS_PER_S     = 1000;
  localparam int ACC_W        = 42;
  localparam int STEP_Q_W     = 10;
  localparam int DV_CNT_W     = 6;
  localparam int RATE_RESET   = 30;
  localparam logic [RATE_W-1:0]   RATE_RESET_V = RATE_W'(RATE_RESET);
  localparam logic [STEP_Q_W-1:0] STEP_Q_RESET = STEP_Q_W'(MS_PER_S / RATE_RESET);
  localparam logic [RATE_W-1:0]   STEP_R_RESET = RATE_W'(MS_PER_S % RATE_RESET);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  // one scan step: an optional unit close followed by an optional kept byte
  typedef struct packed {
    logic                close_vld;
    kind_t               close_kind;
    logic [BYTES_W-1:0]  unit_bytes;
    logic                unit_keyframe;
    logic                byte_vld;
    logic [7:0]          data;
    logic                nal_first;
    logic [4:0]          nal_kind;
    logic                last;
  } entry_t;

  typedef enum logic {
    FE_RUN,
    FE_FLUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_STEP,
    DV_ACC
  } dv_state_t;

endpackage

FILE: rtl/h264_annexb_access_unit_splitter_unit.sv
// top level of the annex-b access unit splitter
// depends on h264au_pkg, h264au_front, h264au_fifo and h264au_back
//
// Usage:
//   in_*  : one stream byte per transfer (in_tdata), in_tlast marks the final
//           byte of a stream. Up to one byte per cycle, as in_tready allows.
//   out_* : results; out_tuser is the kind (kept byte, unit commit, unit
//           discard), out_tlast ends the results of one byte or of one flush.
//   cfg_* : frame rate write; after a write cfg_ready and in_tready stay low
//           while the divider rebuilds the timestamp base.
//   A byte leaves the scan once four newer bytes are in the window; its
//   result reaches out_* via the staging register, queue and result register.
//   After a transfer with in_tlast the window is flushed, one scan step per
//   cycle while the queue has room, and in_tready stays low until the flush
//   ends. A scan step can yield two results (unit close and byte); the result
//   register drains one per cycle while out_tready is high, so a run of such
//   steps fills the 4-entry queue and backs up into in_tready. A stalled
//   receiver holds out_tdata and stops the queue, then the input side.
//   Reset clears the parser, unit counter and timestamp; frame rate goes to 30.
module h264_annexb_access_unit_splitter_unit
  import h264au_pkg::*;
#(
  parameter int UNIT_COUNT_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // stream input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] stream_byte
  input  logic                  in_tlast,   // end_of_stream
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] out_byte, [8] nal_first, [13:9] nal_kind, [37:14] unit_bytes,
  // [38] unit_keyframe, [70:39] unit_index, [102:71] unit_time_ms, [103] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast,  // last_result
  // frame rate register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RATE_W-1:0]     cfg_data    // [7:0] frame_rate
);

  logic   busy;
  logic   push, pop, q_full, q_empty;
  entry_t push_data, pop_data;

  h264au_front #(
    .UNIT_COUNT_BITS(UNIT_COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .hold      (busy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  h264au_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  h264au_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_empty    (q_empty),
    .pop        (pop),
    .q_data     (pop_data),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/h264au_front.sv
// front end: lookahead window, start code scan and access unit bookkeeping
// depends on h264au_pkg; pushes at most one entry per scan step into h264au_fifo
module h264au_front
  import h264au_pkg::*;
#(
  parameter int UNIT_COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       hold,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_data
);

  localparam int CNT_W = (UNIT_COUNT_BITS < BYTES_W) ? UNIT_COUNT_BITS : BYTES_W;
  localparam logic [CNT_W-1:0] CNT_CAP = '1;

  fe_state_t        state_r, state_nxt;
  logic [7:0]       win_r [WIN_DEPTH];
  logic [7:0]       win_nxt [WIN_DEPTH];
  logic [2:0]       fill_r, fill_nxt;
  logic             seen_r, seen_nxt;
  logic [4:0]       type_r, type_nxt;
  logic             kept_r, kept_nxt;
  logic             slice_r, slice_nxt;
  logic             idr_r, idr_nxt;
  logic             nonempty_r, nonempty_nxt;
  logic [CNT_W-1:0] bytes_r, bytes_nxt;
  logic [1:0]       skip_r, skip_nxt;
  entry_t           stg_r, stg_nxt;
  logic             stg_vld_r, stg_vld_nxt;

  logic             advance, acc_in, do_th, do_close, step_end;
  logic [7:0]       w_sel [WIN_DEPTH];
  logic [2:0]       avail;
  logic             sc3, sc4, found;
  logic [4:0]       hdr_type, type_cur;
  logic             hdr_kept, kept_cur, seen_cur;
  logic             close_any, byte_emit;
  logic [CNT_W-1:0] bytes_a;
  entry_t           cand;
  logic             cand_vld;

  assign advance   = !q_full;
  assign in_tready = (state_r == FE_RUN) && !q_full && !hold;
  assign acc_in    = in_tvalid && in_tready;

  // window seen by the scan: the new byte joins it while running
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w_sel[i] = win_r[i];
    end
    if (state_r == FE_RUN) begin
      w_sel[fill_r] = in_tdata;
    end
    avail    = (state_r == FE_RUN) ? 3'(WIN_DEPTH) : fill_r;
    do_th    = (state_r == FE_RUN) ? (acc_in && !in_tlast && fill_r == 3'(WIN_DEPTH - 1))
                                   : (advance && fill_r != '0);
    do_close = (state_r == FE_FLUSH) && advance && (fill_r == '0);
    step_end = (acc_in && !in_tlast) || do_close;
  end

  // start code scan on the oldest window byte
  always_comb begin
    sc3 = (avail >= 3'(WIN_DEPTH - 1)) && (w_sel[0] == SC_ZERO) && (w_sel[1] == SC_ZERO)
          && (w_sel[2] == SC_ONE);
    sc4 = (avail == 3'(WIN_DEPTH)) && (w_sel[0] == SC_ZERO) && (w_sel[1] == SC_ZERO)
          && (w_sel[2] == SC_ZERO) && (w_sel[3] == SC_ONE);
    found     = do_th && (skip_r == '0) && (sc3 || sc4);
    hdr_type  = sc3 ? w_sel[3][4:0] : w_sel[4][4:0];
    hdr_kept  = (hdr_type == NAL_AUD) || (hdr_type == NAL_SPS) || (hdr_type == NAL_PPS)
                || (hdr_type == NAL_SLICE) || (hdr_type == NAL_IDR);
    type_cur  = found ? hdr_type : type_r;
    kept_cur  = found ? hdr_kept : kept_r;
    seen_cur  = seen_r || found;
    close_any = (found && hdr_type == NAL_AUD) || do_close;
    byte_emit = do_th && seen_cur && kept_cur;
  end

  // candidate entry for this step
  always_comb begin
    cand               = '0;
    cand.close_vld     = close_any && (slice_r || nonempty_r);
    cand.close_kind    = slice_r ? KIND_COMMIT : KIND_DISCARD;
    cand.unit_bytes    = BYTES_W'(bytes_r);
    cand.unit_keyframe = slice_r && idr_r;
    cand.byte_vld      = byte_emit;
    cand.data          = w_sel[0];
    cand.nal_first     = found;
    cand.nal_kind      = type_cur;
    cand.last          = step_end;
    cand_vld           = cand.close_vld || cand.byte_vld;
  end

  // staging register holds an entry until it is known whether it ends its step
  always_comb begin
    push           = stg_vld_r && !q_full && (stg_r.last || cand_vld || step_end);
    push_data      = stg_r;
    push_data.last = stg_r.last || (step_end && !cand_vld);
    stg_nxt        = stg_r;
    stg_vld_nxt    = stg_vld_r;
    if (cand_vld) begin
      stg_nxt     = cand;
      stg_vld_nxt = 1'b1;
    end else if (push) begin
      stg_vld_nxt = 1'b0;
    end
  end

  // parser state, unit bookkeeping and window sequencing
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_nxt[i] = win_r[i];
    end
    seen_nxt = seen_r;
    type_nxt = type_r;
    kept_nxt = kept_r;
    skip_nxt = skip_r;
    if (do_th) begin
      seen_nxt = seen_cur;
      type_nxt = type_cur;
      kept_nxt = kept_cur;
      if (found) begin
        skip_nxt = 2'd3;
      end else if (skip_r != '0) begin
        skip_nxt = skip_r - 2'd1;
      end
    end

    // a close clears the unit before this nal's flags and byte count apply
    slice_nxt    = (slice_r && !close_any)
                   || (found && (hdr_type == NAL_SLICE || hdr_type == NAL_IDR));
    idr_nxt      = (idr_r && !close_any) || (found && hdr_type == NAL_IDR);
    nonempty_nxt = (nonempty_r && !close_any) || byte_emit;
    bytes_a      = close_any ? '0 : bytes_r;
    bytes_nxt    = (byte_emit && bytes_a != CNT_CAP) ? bytes_a + 1'b1 : bytes_a;

    unique case (state_r)
      FE_RUN: begin
        if (acc_in) begin
          if (in_tlast) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
              win_nxt[i] = w_sel[i];
            end
            fill_nxt  = fill_r + 3'd1;
            state_nxt = FE_FLUSH;
          end else if (do_th) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
              win_nxt[i] = w_sel[i + 1];
            end
            win_nxt[WIN_DEPTH - 1] = '0;
          end else begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
              win_nxt[i] = w_sel[i];
            end
            fill_nxt = fill_r + 3'd1;
          end
        end
      end
      FE_FLUSH: begin
        if (do_th) begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win_nxt[i] = w_sel[i + 1];
          end
          win_nxt[WIN_DEPTH - 1] = '0;
          fill_nxt = fill_r - 3'd1;
        end else if (do_close) begin
          // end of stream: back to the parser's reset state
          for (int i = 0; i < WIN_DEPTH; i++) begin
            win_nxt[i] = '0;
          end
          fill_nxt  = '0;
          seen_nxt  = 1'b0;
          type_nxt  = '0;
          kept_nxt  = 1'b0;
          skip_nxt  = '0;
          state_nxt = FE_RUN;
        end
      end
      default: begin
        state_nxt = FE_RUN;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_RUN;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      fill_r     <= '0;
      seen_r     <= 1'b0;
      type_r     <= '0;
      kept_r     <= 1'b0;
      slice_r    <= 1'b0;
      idr_r      <= 1'b0;
      nonempty_r <= 1'b0;
      bytes_r    <= '0;
      skip_r     <= '0;
      stg_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
      fill_r     <= fill_nxt;
      seen_r     <= seen_nxt;
      type_r     <= type_nxt;
      kept_r     <= kept_nxt;
      slice_r    <= slice_nxt;
      idr_r      <= idr_nxt;
      nonempty_r <= nonempty_nxt;
      bytes_r    <= bytes_nxt;
      skip_r     <= skip_nxt;
      stg_vld_r  <= stg_vld_nxt;
    end
  end

  // staging payload
  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

`ifndef SYNTHESIS
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FE_FLUSH) |-> !in_tready)
    else $error("input taken during flush");
  a_run_window_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FE_RUN) |-> (fill_r < 3'(WIN_DEPTH)))
    else $error("window full while running");
`endif

endmodule

FILE: rtl/h264au_fifo.sv
// short entry queue between front and back end
// depends on h264au_pkg for entry_t and the queue depth
module h264au_fifo
  import h264au_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");
`endif

endmodule

FILE: rtl/h264au_back.sv
// back end: unit numbering, timestamps, frame rate divider and result register
// depends on h264au_pkg; drains entries from h264au_fifo
module h264au_back
  import h264au_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RATE_W-1:0]     cfg_data,
  input  logic                  q_empty,
  output logic                  pop,
  input  entry_t                q_data,
  output logic                  busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  localparam logic [DV_CNT_W-1:0] DV_LAST = DV_CNT_W'(ACC_W - 1);

  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic [INDEX_W-1:0]  cnt_r, cnt_nxt;
  logic [ACC_W-1:0]    acc_q_r, acc_q_nxt;
  logic [RATE_W-1:0]   acc_r_r, acc_r_nxt;
  logic [STEP_Q_W-1:0] stp_q_r, stp_q_nxt;
  logic [RATE_W-1:0]   stp_r_r, stp_r_nxt;
  dv_state_t           dv_state_r, dv_state_nxt;
  logic [DV_CNT_W-1:0] dv_cnt_r, dv_cnt_nxt;
  logic [ACC_W-1:0]    dv_num_r, dv_num_nxt;
  logic [RATE_W-1:0]   dv_rem_r, dv_rem_nxt;

  logic                out_vld_r, out_vld_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_first_r, out_first_nxt;
  logic [4:0]          out_nkind_r, out_nkind_nxt;
  logic [BYTES_W-1:0]  out_bytes_r, out_bytes_nxt;
  logic                out_key_r, out_key_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic [TIME_W-1:0]   out_time_r, out_time_nxt;
  logic                out_last_r, out_last_nxt;

  logic                pend_vld_r, pend_vld_nxt;
  logic [7:0]          pend_byte_r, pend_byte_nxt;
  logic                pend_first_r, pend_first_nxt;
  logic [4:0]          pend_nkind_r, pend_nkind_nxt;
  logic                pend_last_r, pend_last_nxt;

  logic [RATE_W-1:0]   fr_eff;
  logic                load, take_pend, commit;
  logic [TIME_W-1:0]   time_sat;
  logic [RATE_W:0]     r_sum;
  logic                r_wrap;
  logic [RATE_W:0]     dv_shift, dv_sub;
  logic                dv_ge;
  logic [RATE_W-1:0]   dv_rem_step;
  logic [ACC_W-1:0]    dv_num_step;

  assign busy      = (dv_state_r != DV_IDLE);
  assign cfg_ready = !busy;
  assign fr_eff    = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign load      = !out_vld_r || out_tready;
  assign take_pend = load && pend_vld_r;
  assign pop       = load && !pend_vld_r && !q_empty && !busy;
  assign commit    = pop && q_data.close_vld && (q_data.close_kind == KIND_COMMIT);
  assign time_sat  = (acc_q_r[ACC_W-1:TIME_W] != '0) ? '1 : acc_q_r[TIME_W-1:0];

  // result register and the byte half of a split entry
  always_comb begin
    out_vld_nxt    = out_vld_r;
    out_kind_nxt   = out_kind_r;
    out_byte_nxt   = out_byte_r;
    out_first_nxt  = out_first_r;
    out_nkind_nxt  = out_nkind_r;
    out_bytes_nxt  = out_bytes_r;
    out_key_nxt    = out_key_r;
    out_index_nxt  = out_index_r;
    out_time_nxt   = out_time_r;
    out_last_nxt   = out_last_r;
    pend_vld_nxt   = pend_vld_r;
    pend_byte_nxt  = pend_byte_r;
    pend_first_nxt = pend_first_r;
    pend_nkind_nxt = pend_nkind_r;
    pend_last_nxt  = pend_last_r;
    if (load) begin
      out_vld_nxt   = 1'b0;
      out_kind_nxt  = KIND_BYTE;
      out_byte_nxt  = '0;
      out_first_nxt = 1'b0;
      out_nkind_nxt = '0;
      out_bytes_nxt = '0;
      out_key_nxt   = 1'b0;
      out_index_nxt = '0;
      out_time_nxt  = '0;
      out_last_nxt  = 1'b0;
    end
    if (take_pend) begin
      out_vld_nxt   = 1'b1;
      out_byte_nxt  = pend_byte_r;
      out_first_nxt = pend_first_r;
      out_nkind_nxt = pend_nkind_r;
      out_last_nxt  = pend_last_r;
      pend_vld_nxt  = 1'b0;
    end else if (pop) begin
      out_vld_nxt = 1'b1;
      if (q_data.close_vld) begin
        out_kind_nxt  = q_data.close_kind;
        out_bytes_nxt = q_data.unit_bytes;
        out_key_nxt   = q_data.unit_keyframe;
        out_index_nxt = commit ? cnt_r : '0;
        out_time_nxt  = commit ? time_sat : '0;
        out_last_nxt  = q_data.last && !q_data.byte_vld;
        if (q_data.byte_vld) begin
          pend_vld_nxt   = 1'b1;
          pend_byte_nxt  = q_data.data;
          pend_first_nxt = q_data.nal_first;
          pend_nkind_nxt = q_data.nal_kind;
          pend_last_nxt  = q_data.last;
        end
      end else begin
        out_byte_nxt  = q_data.data;
        out_first_nxt = q_data.nal_first;
        out_nkind_nxt = q_data.nal_kind;
        out_last_nxt  = q_data.last;
      end
    end
  end

  // restoring divider step, one quotient bit per cycle
  always_comb begin
    dv_shift    = {dv_rem_r, dv_num_r[ACC_W-1]};
    dv_ge       = (dv_shift >= {1'b0, fr_eff});
    dv_sub      = dv_shift - {1'b0, fr_eff};
    dv_rem_step = dv_ge ? dv_sub[RATE_W-1:0] : dv_shift[RATE_W-1:0];
    dv_num_step = {dv_num_r[ACC_W-2:0], dv_ge};
  end

  // unit counter, running timestamp and rate reload sequencer
  always_comb begin
    rate_nxt     = rate_r;
    cnt_nxt      = cnt_r;
    acc_q_nxt    = acc_q_r;
    acc_r_nxt    = acc_r_r;
    stp_q_nxt    = stp_q_r;
    stp_r_nxt    = stp_r_r;
    dv_state_nxt = dv_state_r;
    dv_cnt_nxt   = dv_cnt_r;
    dv_num_nxt   = dv_num_r;
    dv_rem_nxt   = dv_rem_r;

    // next index: quotient grows by 1000/rate, remainder wraps at most once
    r_sum  = {1'b0, acc_r_r} + {1'b0, stp_r_r};
    r_wrap = (r_sum >= {1'b0, fr_eff});
    if (commit && cnt_r != '1) begin
      cnt_nxt   = cnt_r + 1'b1;
      acc_r_nxt = r_wrap ? RATE_W'(r_sum - {1'b0, fr_eff}) : r_sum[RATE_W-1:0];
      acc_q_nxt = acc_q_r + ACC_W'(stp_q_r) + ACC_W'(r_wrap);
    end

    unique case (dv_state_r)
      DV_IDLE: begin
        if (cfg_valid) begin
          rate_nxt     = cfg_data;
          dv_num_nxt   = ACC_W'(MS_PER_S);
          dv_rem_nxt   = '0;
          dv_cnt_nxt   = '0;
          dv_state_nxt = DV_STEP;
        end
      end
      DV_STEP: begin
        dv_num_nxt = dv_num_step;
        dv_rem_nxt = dv_rem_step;
        dv_cnt_nxt = dv_cnt_r + 1'b1;
        if (dv_cnt_r == DV_LAST) begin
          stp_q_nxt    = dv_num_step[STEP_Q_W-1:0];
          stp_r_nxt    = dv_rem_step;
          dv_num_nxt   = ACC_W'(cnt_r) * ACC_W'(MS_PER_S);
          dv_rem_nxt   = '0;
          dv_cnt_nxt   = '0;
          dv_state_nxt = DV_ACC;
        end
      end
      DV_ACC: begin
        dv_num_nxt = dv_num_step;
        dv_rem_nxt = dv_rem_step;
        dv_cnt_nxt = dv_cnt_r + 1'b1;
        if (dv_cnt_r == DV_LAST) begin
          acc_q_nxt    = dv_num_step;
          acc_r_nxt    = dv_rem_step;
          dv_state_nxt = DV_IDLE;
        end
      end
      default: begin
        dv_state_nxt = DV_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= RATE_RESET_V;
      cnt_r      <= '0;
      acc_q_r    <= '0;
      acc_r_r    <= '0;
      stp_q_r    <= STEP_Q_RESET;
      stp_r_r    <= STEP_R_RESET;
      dv_state_r <= DV_IDLE;
      dv_cnt_r   <= '0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      rate_r     <= rate_nxt;
      cnt_r      <= cnt_nxt;
      acc_q_r    <= acc_q_nxt;
      acc_r_r    <= acc_r_nxt;
      stp_q_r    <= stp_q_nxt;
      stp_r_r    <= stp_r_nxt;
      dv_state_r <= dv_state_nxt;
      dv_cnt_r   <= dv_cnt_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dv_num_r     <= dv_num_nxt;
    dv_rem_r     <= dv_rem_nxt;
    out_kind_r   <= out_kind_nxt;
    out_byte_r   <= out_byte_nxt;
    out_first_r  <= out_first_nxt;
    out_nkind_r  <= out_nkind_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_key_r    <= out_key_nxt;
    out_index_r  <= out_index_nxt;
    out_time_r   <= out_time_nxt;
    out_last_r   <= out_last_nxt;
    pend_byte_r  <= pend_byte_nxt;
    pend_first_r <= pend_first_nxt;
    pend_nkind_r <= pend_nkind_nxt;
    pend_last_r  <= pend_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_time_r, out_index_r, out_key_r, out_bytes_r,
                       out_nkind_r, out_first_r, out_byte_r};

`ifndef SYNTHESIS
  a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !pop)
    else $error("entry drained during rate reload");
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r >= $past(cnt_r)))
    else $error("unit counter went backwards");
`endif

endmodule
